[src/ptap_pkg.sv]
// Shared types, constants and lookup functions for the point transform core.
package ptap_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TRIG_W            = 32;
    localparam int TRIG_FRAC         = 30;
    localparam int Q_FRAC            = 16;
    localparam int ANGLE_W           = 16;
    localparam int CFG_INDEX_W       = 3;

    typedef enum logic [1:0] {
        OP_MOVE      = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_ROTATE    = 2'd2,
        OP_SCALE     = 2'd3
    } op_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OP_MODE    = 3'd0,
        CFG_ARG_X      = 3'd1,
        CFG_ARG_Y      = 3'd2,
        CFG_TURN_ANGLE = 3'd3,
        CFG_PIVOT_X    = 3'd4,
        CFG_PIVOT_Y    = 3'd5
    } cfg_index_t;

    // Arctangent of 2^-i, 2^32 units per turn.
    function automatic logic [TRIG_W-1:0] atan_lut(input int i);
        logic [TRIG_W-1:0] v;
        unique case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680862;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41721;
            15: v = 32'd20860;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2607;
            19: v = 32'd1303;
            20: v = 32'd651;
            21: v = 32'd325;
            22: v = 32'd162;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Inverse CORDIC gain in Q2.30 for a given iteration count.
    function automatic logic [TRIG_W-1:0] gain_lut(input int stages);
        logic [TRIG_W-1:0] v;
        unique case (stages)
            8:  v = 32'd652039507;
            9:  v = 32'd652034532;
            10: v = 32'd652033289;
            11: v = 32'd652032978;
            12: v = 32'd652032900;
            13: v = 32'd652032881;
            14: v = 32'd652032876;
            default: v = 32'd652032874;
        endcase
        return v;
    endfunction

endpackage

[src/ptap_cordic.sv]
// Pipelined rotation-mode CORDIC producing cosine and sine of a binary angle.
module ptap_cordic
    import ptap_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [ANGLE_W-1:0]       angle,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);

    logic [1:0]               q_reg [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] z_reg [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    logic [ANGLE_W-1:0] angle_bias;
    logic [1:0]         quad;
    logic [ANGLE_W-1:0] resid;

    // Split the angle into the nearest quarter turn and a residual within one eighth turn.
    always_comb begin
        angle_bias = angle + ANGLE_W'(16'h2000);
        quad       = angle_bias[ANGLE_W-1:ANGLE_W-2];
        resid      = angle - {quad, (ANGLE_W-2)'(0)};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0] <= quad;
            x_reg[0] <= $signed(gain_lut(CORDIC_STAGES));
            y_reg[0] <= '0;
            z_reg[0] <= $signed({resid, (TRIG_W-ANGLE_W)'(0)});
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i+1] <= q_reg[i];
                if (z_reg[i][TRIG_W-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(atan_lut(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(atan_lut(i));
                end
            end
        end
    end

    // Turn the residual result back by the quarter turns.
    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (q_reg[CORDIC_STAGES])
                2'd0: begin
                    cos_reg <= x_reg[CORDIC_STAGES];
                    sin_reg <= y_reg[CORDIC_STAGES];
                end
                2'd1: begin
                    cos_reg <= -y_reg[CORDIC_STAGES];
                    sin_reg <= x_reg[CORDIC_STAGES];
                end
                2'd2: begin
                    cos_reg <= -x_reg[CORDIC_STAGES];
                    sin_reg <= -y_reg[CORDIC_STAGES];
                end
                default: begin
                    cos_reg <= y_reg[CORDIC_STAGES];
                    sin_reg <= -x_reg[CORDIC_STAGES];
                end
            endcase
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

[src/point_transform_about_pivot_core.sv]
// Each point passes the delay line, then the multiply, sum, rounding, offset and output registers.
// Throughput: one point per cycle; every stage is registered and the whole pipeline
// holds when the output register is full and m_tready is low.
// Each point runs down a delay line beside the CORDIC, so its cosine and sine arrive with it.
// Reset (synchronous, aresetn low) clears all valid bits and the configuration registers.
module point_transform_about_pivot_core
    import ptap_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [CFG_INDEX_W-1:0]               cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: in_x, in_y, zero fill.
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: out_x, out_y, zero fill.
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    output logic                                 m_tlast,
    // Fields from bit 0: saturated.
    output logic [0:0]                           m_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = ((2*W+7)/8)*8;
    localparam int BW     = (W > TRIG_W) ? W : TRIG_W;
    localparam int PW     = W + 1 + BW;
    localparam int SW     = PW + 2;
    localparam int TW     = SW + 1;
    localparam int DEPTH  = CORDIC_STAGES + 2;

    localparam logic signed [SW-1:0] HALF_TRIG = SW'(1) <<< (TRIG_FRAC-1);
    localparam logic signed [SW-1:0] HALF_Q    = SW'(1) <<< (Q_FRAC-1);
    localparam logic signed [TW-1:0] MAX_T     = (TW'(1) <<< (W-1)) - TW'(1);
    localparam logic signed [TW-1:0] MIN_T     = -(TW'(1) <<< (W-1));
    localparam logic signed [W-1:0]  MAX_W     = MAX_T[W-1:0];
    localparam logic signed [W-1:0]  MIN_W     = MIN_T[W-1:0];

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W:0]   dx;
        logic signed [W:0]   dy;
        logic                last;
    } pay_t;

    // Configuration registers.
    op_mode_t            op_mode_reg;
    logic signed [W-1:0] arg_x_reg;
    logic signed [W-1:0] arg_y_reg;
    logic [ANGLE_W-1:0]  turn_angle_reg;
    logic signed [W-1:0] pivot_x_reg;
    logic signed [W-1:0] pivot_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg    <= OP_MOVE;
            arg_x_reg      <= '0;
            arg_y_reg      <= '0;
            turn_angle_reg <= '0;
            pivot_x_reg    <= '0;
            pivot_y_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OP_MODE:    op_mode_reg    <= op_mode_t'(cfg_wdata[1:0]);
                CFG_ARG_X:      arg_x_reg      <= cfg_wdata;
                CFG_ARG_Y:      arg_y_reg      <= cfg_wdata;
                CFG_TURN_ANGLE: turn_angle_reg <= cfg_wdata[ANGLE_W-1:0];
                CFG_PIVOT_X:    pivot_x_reg    <= cfg_wdata;
                CFG_PIVOT_Y:    pivot_y_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic is_rot;
    assign is_rot   = (op_mode_reg == OP_ROTATE);

    // Every stage moves on together whenever the output register can take a result.
    logic adv;
    logic out_vld_reg;
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // Front stage and the delay line that runs beside the CORDIC.
    pay_t in_pay;
    always_comb begin
        in_pay.x    = $signed(s_tdata[W-1:0]);
        in_pay.y    = $signed(s_tdata[2*W-1:W]);
        in_pay.dx   = (W+1)'(in_pay.x) - (W+1)'(pivot_x_reg);
        in_pay.dy   = (W+1)'(in_pay.y) - (W+1)'(pivot_y_reg);
        in_pay.last = s_tlast;
    end

    pay_t             pay_reg [0:DEPTH-1];
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay_reg[0] <= in_pay;
            for (int k = 1; k < DEPTH; k++) begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;

    ptap_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .angle   (turn_angle_reg),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    // Multiply stage. In scale mode the cross terms are forced to zero.
    pay_t                 mul_pay_reg;
    logic                 mul_vld_reg;
    logic signed [PW-1:0] p0_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [PW-1:0] p3_reg;
    logic signed [BW-1:0] b0;
    logic signed [BW-1:0] b1;
    logic signed [BW-1:0] b3;

    always_comb begin
        b0 = is_rot ? BW'(cos_val) : BW'(arg_x_reg);
        b1 = is_rot ? BW'(sin_val) : '0;
        b3 = is_rot ? BW'(cos_val) : BW'(arg_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_pay_reg <= pay_reg[DEPTH-1];
            p0_reg      <= PW'(pay_reg[DEPTH-1].dx) * PW'(b0);
            p1_reg      <= PW'(pay_reg[DEPTH-1].dy) * PW'(b1);
            p2_reg      <= PW'(pay_reg[DEPTH-1].dx) * PW'(b1);
            p3_reg      <= PW'(pay_reg[DEPTH-1].dy) * PW'(b3);
        end
    end

    // Sum stage.
    pay_t                 sum_pay_reg;
    logic                 sum_vld_reg;
    logic signed [SW-1:0] sx_reg;
    logic signed [SW-1:0] sy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_pay_reg <= mul_pay_reg;
            sx_reg      <= SW'(p0_reg) + SW'(p1_reg);
            sy_reg      <= SW'(p3_reg) - SW'(p2_reg);
        end
    end

    // Rounding stage: divide by the fraction scale, rounding half up.
    pay_t                 rnd_pay_reg;
    logic                 rnd_vld_reg;
    logic signed [SW-1:0] rx_reg;
    logic signed [SW-1:0] ry_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rnd_pay_reg <= sum_pay_reg;
            if (is_rot) begin
                rx_reg <= (sx_reg + HALF_TRIG) >>> TRIG_FRAC;
                ry_reg <= (sy_reg + HALF_TRIG) >>> TRIG_FRAC;
            end else begin
                rx_reg <= (sx_reg + HALF_Q) >>> Q_FRAC;
                ry_reg <= (sy_reg + HALF_Q) >>> Q_FRAC;
            end
        end
    end

    // Offset stage. Translate uses dx + arg, which equals x + (arg - pivot).
    logic                 off_last_reg;
    logic                 off_vld_reg;
    logic signed [TW-1:0] tx_reg;
    logic signed [TW-1:0] ty_reg;
    logic signed [TW-1:0] base_x;
    logic signed [TW-1:0] base_y;
    logic signed [TW-1:0] add_x;
    logic signed [TW-1:0] add_y;

    always_comb begin
        unique case (op_mode_reg)
            OP_MOVE: begin
                base_x = TW'(rnd_pay_reg.x);
                base_y = TW'(rnd_pay_reg.y);
                add_x  = TW'(arg_x_reg);
                add_y  = TW'(arg_y_reg);
            end
            OP_TRANSLATE: begin
                base_x = TW'(rnd_pay_reg.dx);
                base_y = TW'(rnd_pay_reg.dy);
                add_x  = TW'(arg_x_reg);
                add_y  = TW'(arg_y_reg);
            end
            default: begin
                base_x = TW'(rx_reg);
                base_y = TW'(ry_reg);
                add_x  = TW'(pivot_x_reg);
                add_y  = TW'(pivot_y_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            off_last_reg <= rnd_pay_reg.last;
            tx_reg       <= base_x + add_x;
            ty_reg       <= base_y + add_y;
        end
    end

    // Output register with saturation.
    logic signed [W-1:0] out_x_reg;
    logic signed [W-1:0] out_y_reg;
    logic                out_last_reg;
    logic                out_sat_reg;
    logic signed [W-1:0] sat_x;
    logic signed [W-1:0] sat_y;
    logic                clamp_x;
    logic                clamp_y;

    always_comb begin
        clamp_x = 1'b1;
        clamp_y = 1'b1;
        if (tx_reg > MAX_T) begin
            sat_x = MAX_W;
        end else if (tx_reg < MIN_T) begin
            sat_x = MIN_W;
        end else begin
            sat_x   = tx_reg[W-1:0];
            clamp_x = 1'b0;
        end
        if (ty_reg > MAX_T) begin
            sat_y = MAX_W;
        end else if (ty_reg < MIN_T) begin
            sat_y = MIN_W;
        end else begin
            sat_y   = ty_reg[W-1:0];
            clamp_y = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg    <= sat_x;
            out_y_reg    <= sat_y;
            out_last_reg <= off_last_reg;
            out_sat_reg  <= clamp_x || clamp_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            rnd_vld_reg <= 1'b0;
            off_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            mul_vld_reg <= vld_reg[DEPTH-1];
            sum_vld_reg <= mul_vld_reg;
            rnd_vld_reg <= sum_vld_reg;
            off_vld_reg <= rnd_vld_reg;
            out_vld_reg <= off_vld_reg;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = DW'({out_y_reg, out_x_reg});
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule
